/* hdl/vtp_pkg.sv */
package vtp_pkg;

	localparam int NUM_PARAMS_DEF = 3;
	localparam int PARAM_BITS_DEF = 16;

	localparam int CMD_W  = 4;
	localparam int CHAR_W = 8;
	localparam int ARG_W  = 16;
	localparam int ATTR_W = 8;
	localparam int COLOR_W = 3;

	localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1b;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5b;
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
	localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3f;
	localparam logic [CHAR_W-1:0] CH_M      = 8'h6d;
	localparam logic [CHAR_W-1:0] CH_N      = 8'h6e;
	localparam logic [CHAR_W-1:0] CH_UP     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_DOWN   = 8'h42;
	localparam logic [CHAR_W-1:0] CH_RIGHT  = 8'h43;
	localparam logic [CHAR_W-1:0] CH_LEFT   = 8'h44;
	localparam logic [CHAR_W-1:0] CH_EL     = 8'h4b;
	localparam logic [CHAR_W-1:0] CH_ED     = 8'h4a;
	localparam logic [CHAR_W-1:0] CH_CUP    = 8'h48;
	localparam logic [CHAR_W-1:0] CH_SET    = 8'h68;
	localparam logic [CHAR_W-1:0] CH_RESET  = 8'h6c;

	localparam int FG_LO = 30;
	localparam int FG_HI = 37;
	localparam int BG_LO = 40;
	localparam int BG_HI = 47;
	localparam int MODE_CKM  = 1;
	localparam int MODE_CVIS = 25;
	localparam int DSR_POS   = 6;
	localparam int ED_MAX    = 2;

	localparam logic [COLOR_W-1:0] FG_RESET = 3'd7;
	localparam logic [COLOR_W-1:0] BG_RESET = 3'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_PRINT      = 4'd0,
		CMD_CR         = 4'd1,
		CMD_LF         = 4'd2,
		CMD_SET_ATTR   = 4'd3,
		CMD_REPORT_POS = 4'd4,
		CMD_UP         = 4'd5,
		CMD_DOWN       = 4'd6,
		CMD_RIGHT      = 4'd7,
		CMD_LEFT       = 4'd8,
		CMD_ERASE_EOL  = 4'd9,
		CMD_ERASE_SCR  = 4'd10,
		CMD_SET_POS    = 4'd11,
		CMD_CURSOR_VIS = 4'd12
	} cmd_t;

	typedef enum logic [4:0] {
		ST_NORMAL  = 5'b00001,
		ST_ESC     = 5'b00010,
		ST_NUM     = 5'b00100,
		ST_SWALLOW = 5'b01000,
		ST_MODE    = 5'b10000
	} parse_state_t;

	typedef struct packed {
		cmd_t                command;
		logic [CHAR_W-1:0]   print_char;
		logic [ARG_W-1:0]    arg_a;
		logic [ARG_W-1:0]    arg_b;
		logic [ATTR_W-1:0]   attribute;
		logic                cursor_keys_ansi;
	} result_t;

	// ANSI order is red in bit 0; console order is blue in bit 0
	function automatic logic [COLOR_W-1:0] swap_rb(input logic [COLOR_W-1:0] c);
		return {c[0], c[1], c[2]};
	endfunction

	function automatic logic [ATTR_W-1:0] make_attr(input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg, input logic bright);
		return {1'b0, swap_rb(bg), bright, swap_rb(fg)};
	endfunction

endpackage

/* hdl/vtp_byte_if.sv */
interface vtp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

/* hdl/vtp_cmd_if.sv */
interface vtp_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [7:0]  print_char;
	logic [15:0] arg_a;
	logic [15:0] arg_b;
	logic [7:0]  attribute;
	logic        cursor_keys_ansi;

	modport source (output valid, output command, output print_char, output arg_a,
		output arg_b, output attribute, output cursor_keys_ansi, input ready);
	modport sink (input valid, input command, input print_char, input arg_a,
		input arg_b, input attribute, input cursor_keys_ansi, output ready);
endinterface

/* hdl/vt100_escape_parser.sv */
// Any command from a buffered byte is registered once the output stage is free.
// Throughput: one byte per cycle while the display side takes commands.
// Pipeline: input register, single-pass parse logic, command register.
// Reset: arst_n clears both stages and returns the parser to plain text,
// colors to white on black, and cursor key mode to ANSI.
module vt100_escape_parser import vtp_pkg::*; #(
	parameter int NUM_PARAMS = NUM_PARAMS_DEF,
	parameter int PARAM_BITS = PARAM_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vtp_byte_if.sink  stream,
	vtp_cmd_if.source display
);

	logic              valid_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              out_free;
	logic              advance;
	logic              emit;
	result_t           result;

	assign advance      = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			ch_s1 <= stream.ch;
		end
	end

	vtp_parse_core #(
		.NUM_PARAMS(NUM_PARAMS),
		.PARAM_BITS(PARAM_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (ch_s1),
		.emit   (emit),
		.result (result)
	);

	vtp_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && emit),
		.result  (result),
		.free    (out_free),
		.display (display)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(ch_s1))
		else $error("stalled input byte lost");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> display.valid)
		else $error("command not registered");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> stream.ready)
		else $error("empty input stage refused a byte");

endmodule

/* hdl/vtp_parse_core.sv */
module vtp_parse_core import vtp_pkg::*; #(
	parameter int NUM_PARAMS = NUM_PARAMS_DEF,
	parameter int PARAM_BITS = PARAM_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] ch,
	output logic              emit,
	output result_t           result
);

	localparam int IDX_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARAMS - 1);
	localparam int P1 = (NUM_PARAMS > 1) ? 1 : 0;

	parse_state_t                state_q, state_d;
	logic [PARAM_BITS-1:0]       params_q [NUM_PARAMS];
	logic [PARAM_BITS-1:0]       params_d [NUM_PARAMS];
	logic [IDX_W-1:0]            idx_q, idx_d;
	logic [COLOR_W-1:0]          fg_q, fg_d, bg_q, bg_d;
	logic                        bright_q, bright_d;
	logic                        ckm_q, ckm_d;
	logic [PARAM_BITS-1:0]       p0, p1, n0, acc, mode_acc;
	logic                        is_digit, en;
	cmd_t                        cmd;
	logic [CHAR_W-1:0]           pc;
	logic [ARG_W-1:0]            arg_a, arg_b;

	function automatic logic [PARAM_BITS-1:0] add_digit(input logic [PARAM_BITS-1:0] v,
			input logic [3:0] d);
		logic [PARAM_BITS+3:0] r;
		r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{PARAM_BITS{1'b0}}, d};
		return (r[PARAM_BITS+3:PARAM_BITS] != 4'd0) ? {PARAM_BITS{1'b1}}
			: r[PARAM_BITS-1:0];
	endfunction

	assign p0       = params_q[0];
	assign p1       = (NUM_PARAMS > 1) ? params_q[P1] : '0;
	assign n0       = (p0 == '0) ? PARAM_BITS'(1) : p0;
	assign is_digit = (ch >= CH_0) && (ch <= CH_9);
	assign acc      = add_digit(params_q[idx_q], ch[3:0]);
	assign mode_acc = add_digit(p0, ch[3:0]);
	assign en       = (ch == CH_SET);

	always_comb begin
		state_d  = state_q;
		params_d = params_q;
		idx_d    = idx_q;
		fg_d     = fg_q;
		bg_d     = bg_q;
		bright_d = bright_q;
		ckm_d    = ckm_q;
		emit     = 1'b0;
		cmd      = CMD_PRINT;
		pc       = '0;
		arg_a    = '0;
		arg_b    = '0;
		case (state_q)
			ST_NORMAL: begin
				if (ch == CH_ESC) begin
					for (int i = 0; i < NUM_PARAMS; i++) begin
						params_d[i] = '0;
					end
					idx_d   = '0;
					state_d = ST_ESC;
				end else if (ch == CH_CR) begin
					emit = 1'b1;
					cmd  = CMD_CR;
				end else if (ch == CH_LF) begin
					emit = 1'b1;
					cmd  = CMD_LF;
				end else begin
					emit = 1'b1;
					cmd  = CMD_PRINT;
					pc   = ch;
				end
			end
			ST_ESC: begin
				if (ch == CH_LBRACK) begin
					state_d = ST_NUM;
				end else if (ch == CH_HASH || ch == CH_LPAREN || ch == CH_RPAREN) begin
					state_d = ST_SWALLOW;
				end else begin
					state_d = ST_NORMAL;
				end
			end
			ST_NUM: begin
				if (is_digit) begin
					params_d[idx_q] = acc;
				end else if (ch == CH_SEMI) begin
					if (idx_q == LAST_IDX) begin
						state_d = ST_NORMAL;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end else if (ch == CH_QMARK) begin
					state_d = ST_MODE;
				end else begin
					state_d = ST_NORMAL;
					case (ch)
						CH_M: begin
							for (int i = 0; i < NUM_PARAMS; i++) begin
								if (IDX_W'(i) <= idx_q) begin
									if (params_q[i] inside {[FG_LO:FG_HI]}) begin
										fg_d = COLOR_W'(params_q[i][2:0] + 3'd2);
									end else if (params_q[i] inside {[BG_LO:BG_HI]}) begin
										bg_d = params_q[i][2:0];
									end else if (params_q[i] == '0) begin
										fg_d     = FG_RESET;
										bg_d     = BG_RESET;
										bright_d = 1'b0;
									end else if (params_q[i] == PARAM_BITS'(1)) begin
										bright_d = 1'b1;
									end
								end
							end
							emit = 1'b1;
							cmd  = CMD_SET_ATTR;
						end
						CH_N: begin
							emit = (p0 == PARAM_BITS'(DSR_POS));
							cmd  = CMD_REPORT_POS;
						end
						CH_UP: begin
							emit  = 1'b1;
							cmd   = CMD_UP;
							arg_a = ARG_W'(n0);
						end
						CH_DOWN: begin
							emit  = 1'b1;
							cmd   = CMD_DOWN;
							arg_a = ARG_W'(n0);
						end
						CH_RIGHT: begin
							emit  = 1'b1;
							cmd   = CMD_RIGHT;
							arg_a = ARG_W'(n0);
						end
						CH_LEFT: begin
							emit  = 1'b1;
							cmd   = CMD_LEFT;
							arg_a = ARG_W'(n0);
						end
						CH_EL: begin
							emit = 1'b1;
							cmd  = CMD_ERASE_EOL;
						end
						CH_ED: begin
							emit  = (p0 <= PARAM_BITS'(ED_MAX));
							cmd   = CMD_ERASE_SCR;
							arg_a = ARG_W'(p0);
						end
						CH_CUP: begin
							emit  = 1'b1;
							cmd   = CMD_SET_POS;
							arg_a = ARG_W'(p0);
							arg_b = ARG_W'(p1);
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			ST_MODE: begin
				if (is_digit) begin
					params_d[0] = mode_acc;
				end else begin
					state_d = ST_NORMAL;
					if (ch == CH_SET || ch == CH_RESET) begin
						if (p0 == PARAM_BITS'(MODE_CKM)) begin
							ckm_d = en;
						end else if (p0 == PARAM_BITS'(MODE_CVIS)) begin
							emit  = 1'b1;
							cmd   = CMD_CURSOR_VIS;
							arg_a = ARG_W'(en);
						end
					end
				end
			end
			default: begin
				state_d = ST_NORMAL;
			end
		endcase
	end

	assign result.command          = cmd;
	assign result.print_char       = pc;
	assign result.arg_a            = arg_a;
	assign result.arg_b            = arg_b;
	assign result.attribute        = make_attr(fg_d, bg_d, bright_d);
	assign result.cursor_keys_ansi = ckm_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_NORMAL;
			idx_q    <= '0;
			fg_q     <= FG_RESET;
			bg_q     <= BG_RESET;
			bright_q <= 1'b0;
			ckm_q    <= 1'b1;
			for (int i = 0; i < NUM_PARAMS; i++) begin
				params_q[i] <= '0;
			end
		end else if (step) begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			fg_q     <= fg_d;
			bg_q     <= bg_d;
			bright_q <= bright_d;
			ckm_q    <= ckm_d;
			params_q <= params_d;
		end
	end

	a_esc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && state_q == ST_NORMAL && ch == CH_ESC |=> state_q == ST_ESC && idx_q == '0)
		else $error("escape did not clear parameter index");

	a_esc_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ESC |-> !emit)
		else $error("result produced directly after escape");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(state_q) && $stable(idx_q) && $stable(ckm_q))
		else $error("parser state moved without a byte");

endmodule

/* hdl/vtp_out_stage.sv */
module vtp_out_stage import vtp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  result_t  result,
	output logic     free,
	vtp_cmd_if.source display
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || display.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (display.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign display.valid            = valid_q;
	assign display.command          = res_q.command;
	assign display.print_char       = res_q.print_char;
	assign display.arg_a            = res_q.arg_a;
	assign display.arg_b            = res_q.arg_b;
	assign display.attribute        = res_q.attribute;
	assign display.cursor_keys_ansi = res_q.cursor_keys_ansi;

endmodule
